// ===== hdl/lphs_pkg.sv =====
// ============================================================================
// lphs_pkg
// Shared types, codes and field widths of the linear probing hash set.
// ============================================================================
package lphs_pkg;

    // Field widths of the request and result beats.
    localparam int KEY_W  = 31;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 6;

    // Configuration port.
    localparam int TSIZE_W    = 7;
    localparam int THR_W      = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Default geometry and register reset values.
    localparam int DEF_SLOTS = 64;
    localparam logic [TSIZE_W-1:0] TSIZE_RST = 7'd64;
    localparam logic [THR_W-1:0]   THR_RST   = 9'd192;

    // Width of the bit counter of the modulo unit.
    localparam int STEP_W = $clog2(KEY_W);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_THRESHOLD = 1'd1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_FIND,
        S_DECIDE
    } t_state;

endpackage

// ===== hdl/linear_probe_hash_set.sv =====
// ============================================================================
// linear_probe_hash_set
// Set of 31-bit keys in an open addressed table with linear probing.
// ============================================================================
// Usage: a request beat (req_type, key) enters on the in channel; one result
// beat (success, status, slot) leaves on the out channel for every request.
// Insert adds a key, search looks it up, remove replaces it by a tombstone.
// Each request runs through one shared sequencer: a bit-serial restoring
// remainder unit computes the home slot, then the probe walk reads one slot
// of the key memory per cycle, at most m slots (m = table size), then the
// decision state updates the table and loads the result register. The next
// request is taken in the cycle after the result is loaded.
// The result sits in an output register until taken; a stalled receiver
// holds the decision cycle of the following request but not its probe walk.
// Synchronous reset empties the table (occupied and tombstone bits, count)
// at once and sets table_size to 64 and load_threshold to 192.
// Configuration writes take effect at the next clock edge. They are to be
// made only while no request is in flight; the block does not enforce this.
// ============================================================================
module linear_probe_hash_set #(
    parameter int SLOTS = lphs_pkg::DEF_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [lphs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lphs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lphs_pkg::REQ_W-1:0]       i_req_type,
    input  logic [lphs_pkg::KEY_W-1:0]       i_key,
    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_success,
    output logic [lphs_pkg::STAT_W-1:0]      o_status,
    output logic [lphs_pkg::SLOT_W-1:0]      o_slot
);
    import lphs_pkg::*;

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW   = $clog2(SLOTS + 1);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int LW   = CNTW + THR_W + MW;

    // Configuration registers.
    logic [TSIZE_W-1:0] r_table_size;
    logic [THR_W-1:0]   r_load_thr;

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [KEY_W-1:0]   r_shift, n_shift;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [IW-1:0]      r_rem, n_rem;
    logic [IW-1:0]      r_pos, n_pos;
    logic [IW-1:0]      r_cnt, n_cnt;
    logic               r_hit, n_hit;
    logic               r_free_ok, n_free_ok;
    logic [IW-1:0]      r_free_pos, n_free_pos;

    // Table state.
    logic [KEY_W-1:0]   r_mem [SLOTS];
    logic [KEY_W-1:0]   r_rdata;
    logic [SLOTS-1:0]   r_occ, r_tomb;
    logic [CNTW-1:0]    r_count;

    // Result register.
    logic               r_o_valid;
    logic               r_o_success;
    logic [STAT_W-1:0]  r_o_status;
    logic [SLOT_W-1:0]  r_o_slot;

    // Decision outputs.
    logic               res_load;
    logic               res_success;
    logic [STAT_W-1:0]  res_status;
    logic [IW-1:0]      res_pos;
    logic               do_insert;
    logic               do_remove;

    logic [MW-1:0]      m;
    logic [IW:0]        rem_t;
    logic [IW:0]        pos_inc;
    logic [IW:0]        m_x;
    logic               cur_occ;
    logic               cur_tomb;
    logic               load_over;
    logic               out_free;
    logic [LW-1:0]      load_lhs;
    logic [LW-1:0]      load_rhs;
    logic [IW+SLOT_W-1:0] slot_x;

    // Effective table size: zero counts as one, large values saturate.
    always_comb begin
        if (r_table_size == '0) begin
            m = MW'(1);
        end else if (int'(r_table_size) > SLOTS) begin
            m = MW'(SLOTS);
        end else begin
            m = MW'(r_table_size);
        end
    end

    assign m_x      = (IW+1)'(m);
    assign rem_t    = {r_rem, r_shift[KEY_W-1]};
    assign pos_inc  = {1'b0, r_pos} + (IW+1)'(1);
    assign cur_occ  = r_occ[r_pos];
    assign cur_tomb = r_tomb[r_pos];
    assign out_free = !r_o_valid || i_out_ready;

    // Load check: count / m > threshold / 256, compared exactly.
    assign load_lhs  = LW'(r_count) << 8;
    assign load_rhs  = LW'(r_load_thr) * LW'(m);
    assign load_over = load_lhs > load_rhs;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_step == '0) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if ((!cur_occ && !cur_tomb) || (cur_occ && r_rdata == r_key) ||
                    (MW'(r_cnt) == m - MW'(1))) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath next values: remainder unit and probe walk.
    always_comb begin
        n_req      = r_req;
        n_key      = r_key;
        n_shift    = r_shift;
        n_step     = r_step;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_hit      = r_hit;
        n_free_ok  = r_free_ok;
        n_free_pos = r_free_pos;
        case (r_state)
            S_IDLE: begin
                n_req   = i_req_type;
                n_key   = i_key;
                n_shift = i_key;
                n_step  = STEP_W'(KEY_W - 1);
                n_rem   = '0;
            end
            S_MOD: begin
                // One restoring step per key bit, most significant first.
                n_shift = r_shift << 1;
                n_step  = r_step - STEP_W'(1);
                if (rem_t >= m_x) begin
                    n_rem = IW'(rem_t - m_x);
                end else begin
                    n_rem = IW'(rem_t);
                end
                if (r_step == '0) begin
                    n_pos     = n_rem;
                    n_cnt     = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                end
            end
            S_FIND: begin
                // Remember the first slot not occupied along the walk.
                if (!cur_occ && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_pos = r_pos;
                end
                if (cur_occ && r_rdata == r_key) begin
                    n_hit = 1'b1;
                end else if (cur_occ || cur_tomb) begin
                    if (MW'(r_cnt) != m - MW'(1)) begin
                        n_cnt = r_cnt + IW'(1);
                        if (pos_inc == m_x) begin
                            n_pos = '0;
                        end else begin
                            n_pos = IW'(pos_inc);
                        end
                    end
                end
            end
            S_DECIDE: begin
            end
            default: begin
            end
        endcase
    end

    // Result of a finished walk and the table update it calls for.
    always_comb begin
        res_load    = (r_state == S_DECIDE) && out_free;
        res_success = 1'b0;
        res_status  = ST_MISS;
        res_pos     = '0;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        if (r_hit) begin
            res_success = 1'b1;
            res_status  = ST_OK;
            res_pos     = r_pos;
            do_remove   = (r_req == REQ_REMOVE);
        end else if (r_req == REQ_INSERT) begin
            if (load_over || !r_free_ok) begin
                res_status = ST_FULL;
            end else begin
                res_success = 1'b1;
                res_status  = ST_OK;
                res_pos     = r_free_pos;
                do_insert   = 1'b1;
            end
        end
        if (!res_load) begin
            do_insert = 1'b0;
            do_remove = 1'b0;
        end
    end

    assign slot_x = (IW+SLOT_W)'(res_pos);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= TSIZE_RST;
            r_load_thr   <= THR_RST;
            r_occ        <= '0;
            r_tomb       <= '0;
            r_count      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TABLE_SIZE:     r_table_size <= i_cfg_data[TSIZE_W-1:0];
                    CFG_LOAD_THRESHOLD: r_load_thr   <= i_cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (do_insert) begin
                r_occ[r_free_pos]  <= 1'b1;
                r_tomb[r_free_pos] <= 1'b0;
                r_count            <= r_count + CNTW'(1);
            end
            if (do_remove) begin
                r_occ[r_pos]  <= 1'b0;
                r_tomb[r_pos] <= 1'b1;
                if (r_count != '0) begin
                    r_count <= r_count - CNTW'(1);
                end
            end
            if (res_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_key      <= n_key;
        r_shift    <= n_shift;
        r_step     <= n_step;
        r_rem      <= n_rem;
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_hit      <= n_hit;
        r_free_ok  <= n_free_ok;
        r_free_pos <= n_free_pos;
        if (res_load) begin
            r_o_success <= res_success;
            r_o_status  <= res_status;
            r_o_slot    <= slot_x[SLOT_W-1:0];
        end
    end

    // Key memory: written on insert, read ahead at the next probe slot.
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_mem[r_free_pos] <= r_key;
        end
        r_rdata <= r_mem[n_pos];
    end

    assign o_out_valid = r_o_valid;
    assign o_success   = r_o_success;
    assign o_status    = r_o_status;
    assign o_slot      = r_o_slot;

`ifndef NO_ASSERTIONS
    // The probe position stays inside the active table during the walk.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> ((IW+1)'(r_pos) < m_x))
        else $error("probe position outside the table");

    // A slot is never occupied and tombstoned at once.
    a_occ_tomb_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ & r_tomb) == '0)
        else $error("slot both occupied and tombstoned");

    // The entry count matches the number of occupied slots.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_occ) == int'(r_count))
        else $error("entry count out of step with occupied bits");

    // An accepted request starts the remainder unit.
    a_accept_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MOD))
        else $error("accepted request did not start the remainder unit");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && r_o_valid) |-> i_out_ready)
        else $error("result register overwritten before it was taken");
`endif

endmodule

// ===== bench/tb_linear_probe_hash_set.sv =====
// ============================================================================
// tb_linear_probe_hash_set
// Self-checking bench for the linear probing hash set. Directed and random
// insert, search and remove beats run against a behavioral copy of the
// table. Every result beat is compared field by field, in order.
// ============================================================================
module tb_linear_probe_hash_set;
    timeunit 1ns;
    timeprecision 1ps;

    import lphs_pkg::*;

    // Request code that the block treats as a search.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int NSLOT = DEF_SLOTS;
    localparam int SHOWN_ERRORS = 10;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic              success;
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } t_set_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [REQ_W-1:0]      i_req_type = '0;
    logic [KEY_W-1:0]      i_key = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_success;
    logic [STAT_W-1:0]     o_status;
    logic [SLOT_W-1:0]     o_slot;

    // Mirror of the table contents and of the two registers.
    logic [TSIZE_W-1:0]    mirror_size = TSIZE_RST;
    logic [THR_W-1:0]      mirror_thr = THR_RST;
    logic [KEY_W-1:0]      mirror_keys [NSLOT];
    bit                    mirror_used [NSLOT];
    bit                    mirror_dead [NSLOT];
    int unsigned           mirror_count = 0;

    // Replies still owed by the block, oldest first.
    t_set_reply            outstanding_replies [$];

    int                    snd_idle_pct = 0;
    int                    rcv_idle_pct = 0;
    int                    mismatch_count = 0;
    int                    n_req [4] = '{0, 0, 0, 0};
    int                    n_checked = 0;
    int                    n_ok = 0;
    int                    n_miss = 0;
    int                    n_full = 0;
    int                    n_configs = 0;

    linear_probe_hash_set u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_success   (o_success),
        .o_status    (o_status),
        .o_slot      (o_slot)
    );

    // Clock generation.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Applies one request to the mirror table and returns the reply it owes.
    function automatic t_set_reply apply_set_op(input logic [REQ_W-1:0] req,
                                                input logic [KEY_W-1:0] key);
        int unsigned m;
        int unsigned home;
        int unsigned p;
        int unsigned found_at;
        bit          hit;
        bit          stop;
        t_set_reply  r;
        m = 32'(mirror_size);
        if (m == 0) m = 1;
        if (m > NSLOT) m = NSLOT;
        home = key % m;
        hit = 1'b0;
        stop = 1'b0;
        found_at = 0;
        // Search walk: ends at a never-used slot, at the matching key, or after m slots.
        for (int unsigned i = 0; i < m && !stop; i++) begin
            p = (home + i) % m;
            if (!mirror_used[p] && !mirror_dead[p]) begin
                stop = 1'b1;
            end else if (mirror_used[p] && mirror_keys[p] == key) begin
                hit = 1'b1;
                found_at = p;
                stop = 1'b1;
            end
        end
        r.success = 1'b0;
        r.status = ST_MISS;
        r.slot = '0;
        if (req == REQ_INSERT) begin
            r.status = ST_FULL;
            if (hit) begin
                r.success = 1'b1;
                r.status = ST_OK;
                r.slot = found_at[SLOT_W-1:0];
            end else if (mirror_count * 256 <= mirror_thr * m) begin
                // Place the key in the first slot that is empty or a tombstone.
                stop = 1'b0;
                for (int unsigned i = 0; i < m && !stop; i++) begin
                    p = (home + i) % m;
                    if (!mirror_used[p]) begin
                        mirror_keys[p] = key;
                        mirror_used[p] = 1'b1;
                        mirror_dead[p] = 1'b0;
                        mirror_count++;
                        r.success = 1'b1;
                        r.status = ST_OK;
                        r.slot = p[SLOT_W-1:0];
                        stop = 1'b1;
                    end
                end
            end
        end else if (hit) begin
            if (req == REQ_REMOVE) begin
                mirror_used[found_at] = 1'b0;
                mirror_dead[found_at] = 1'b1;
                if (mirror_count > 0) mirror_count--;
            end
            r.success = 1'b1;
            r.status = ST_OK;
            r.slot = found_at[SLOT_W-1:0];
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS) $display("ERROR: %s", msg);
    endtask

    // Receiver side: ready is dropped at random per cycle.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Result checker: each result beat against the oldest owed reply.
    always @(posedge i_clk) begin
        t_set_reply got;
        t_set_reply want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got = '{o_success, o_status, o_slot};
            n_checked++;
            case (got.status)
                ST_OK:   n_ok++;
                ST_MISS: n_miss++;
                ST_FULL: n_full++;
                default: ;
            endcase
            if (outstanding_replies.size() == 0) begin
                report_error($sformatf("result beat with no request outstanding: %0d/%0d/%0d",
                                       got.success, got.status, got.slot));
            end else begin
                want = outstanding_replies.pop_front();
                if (got !== want) begin
                    report_error($sformatf(
                        "expected success=%0d status=%0d slot=%0d, got %0d %0d %0d",
                        want.success, want.status, want.slot,
                        got.success, got.status, got.slot));
                end
            end
        end
    end

    // Sends one request beat after a random gap and records its reply.
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key <= key;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        outstanding_replies.push_back(apply_set_op(req, key));
        n_req[req]++;
    endtask

    // Holds off new requests until every owed reply has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (outstanding_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers back to back; only called while the block is idle.
    task automatic set_config(input int unsigned tsize, input int unsigned thr);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TABLE_SIZE;
        i_cfg_data <= tsize[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_LOAD_THRESHOLD;
        i_cfg_data <= thr[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror_size = tsize[TSIZE_W-1:0];
        mirror_thr = thr[THR_W-1:0];
        n_configs++;
    endtask

    // Basic operations at the reset settings: collisions, duplicates, tombstones.
    task automatic test_basic_ops();
        send_req(REQ_INSERT, 31'd0);
        send_req(REQ_INSERT, 31'h7FFF_FFFF);
        send_req(REQ_INSERT, 31'd64);
        send_req(REQ_INSERT, 31'd0);
        send_req(REQ_SEARCH, 31'd64);
        send_req(REQ_SEARCH, 31'd128);
        send_req(REQ_REMOVE, 31'd0);
        send_req(REQ_SEARCH, 31'd64);
        send_req(REQ_REMOVE, 31'd0);
        send_req(REQ_UNUSED, 31'd64);
        send_req(REQ_INSERT, 31'd128);
    endtask

    // Refusal with no free slot in a one-slot table, and thresholds of one and above one.
    task automatic test_load_limits();
        wait_idle();
        set_config(1, 256);
        send_req(REQ_INSERT, 31'd5);
        send_req(REQ_SEARCH, 31'd128);
        send_req(REQ_REMOVE, 31'd128);
        send_req(REQ_INSERT, 31'd5);
        wait_idle();
        set_config(0, 511);
        send_req(REQ_INSERT, 31'd7);
        send_req(REQ_SEARCH, 31'd5);
    endtask

    // Table size saturation, masking of the data word, and a shrunk table.
    task automatic test_size_limits();
        wait_idle();
        set_config(127, 0);
        send_req(REQ_INSERT, 31'd9);
        send_req(REQ_SEARCH, 31'h7FFF_FFFF);
        wait_idle();
        set_config(9'h1C8, 128);
        send_req(REQ_INSERT, 31'd77);
        wait_idle();
        set_config(8, 192);
        send_req(REQ_SEARCH, 31'h7FFF_FFFF);
        send_req(REQ_INSERT, 31'd15);
        send_req(REQ_UNUSED, 31'd15);
    endtask

    // Random traffic in three segments, each with its own register settings.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input int n_items);
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] key;
        logic [REQ_W-1:0] req;
        int unsigned      pick;
        int unsigned      tsize;
        int unsigned      thr;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int seg = 0; seg < 3; seg++) begin
            wait_idle();
            case ($urandom_range(9))
                0:       tsize = 1;
                1:       tsize = 64;
                2:       tsize = $urandom_range(1) ? 0 : $urandom_range(127, 65);
                3, 4, 5: tsize = $urandom_range(8, 2);
                default: tsize = $urandom_range(64, 9);
            endcase
            case ($urandom_range(5))
                0:       thr = 0;
                1:       thr = 256;
                2:       thr = $urandom_range(511, 257);
                default: thr = $urandom_range(255, 64);
            endcase
            set_config(tsize, thr);
            key_pool.delete();
            for (int i = 0; i < n_items / 3; i++) begin
                // Mostly keys already seen, so searches and removes find them.
                pick = $urandom_range(99);
                if (key_pool.size() != 0 && pick < 65) begin
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                end else if (pick < 80) begin
                    key = KEY_W'($urandom_range(255));
                end else if (pick < 90) begin
                    key = KEY_W'(31'h7FFF_FFFF - $urandom_range(255));
                end else begin
                    key = KEY_W'($urandom() & 32'h7FFF_FFFF);
                end
                pick = $urandom_range(99);
                if (pick < 40) req = REQ_INSERT;
                else if (pick < 70) req = REQ_SEARCH;
                else if (pick < 94) req = REQ_REMOVE;
                else req = REQ_UNUSED;
                if (req == REQ_INSERT) begin
                    key_pool.push_back(key);
                    if (key_pool.size() > 24) void'(key_pool.pop_front());
                end
                // Now and then the sender waits for the block to drain.
                if ($urandom_range(149) == 0) wait_idle();
                send_req(req, key);
            end
        end
        wait_idle();
    endtask

    // Test sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_load_limits();
        test_size_limits();
        test_random_traffic(35, 87, 600);
        test_random_traffic(87, 35, 600);
        test_random_traffic(0, 0, 600);
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (outstanding_replies.size() != 0) begin
            report_error($sformatf("%0d replies never arrived", outstanding_replies.size()));
        end
        $display("Ran %0d inserts, %0d searches, %0d removes, %0d unused-code requests",
                 n_req[REQ_INSERT], n_req[REQ_SEARCH], n_req[REQ_REMOVE], n_req[REQ_UNUSED]);
        $display("over %0d register settings; %0d results: %0d ok, %0d miss, %0d full",
                 n_configs, n_checked, n_ok, n_miss, n_full);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
